// File: rtl/core/lwfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar wall-follow steering package
// Shared widths, codes, angle windows, reset values and the structs passed
// between the top level and the steering arithmetic.
// ----------------------------------------------------------------------------
package lwfs_pkg;

    // Field widths
    localparam int ANGLE_W  = 15;
    localparam int QUAL_W   = 8;
    localparam int DIST_W   = 16;
    localparam int FRONT_W  = 19;
    localparam int DIFF_W   = 17;
    localparam int STEER_W  = 12;
    localparam int STOPD_W  = 18;
    localparam int THR_W    = 16;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 3;

    // Item kinds carried in the input tuser bit
    localparam logic OP_NODE     = 1'b0;
    localparam logic OP_SCAN_END = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEER_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DIST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_THR   = 3'd4;

    // Configuration reset values
    localparam logic [STEER_W-1:0] STEER_MIN_RST   = 12'd1250;
    localparam logic [STEER_W-1:0] STEER_MAX_RST   = 12'd1810;
    localparam logic [STEER_W-1:0] STEER_START_RST = 12'd1540;
    localparam logic [STOPD_W-1:0] STOP_DIST_RST   = 18'd8800;
    localparam logic [THR_W-1:0]   DERIV_THR_RST   = 16'd4;

    // Front distance before any sample: 100 m in quarter millimeters
    localparam logic [FRONT_W-1:0] FRONT_RST = 19'd400000;

    // Angle windows in 1/64 degree, both bounds exclusive
    localparam logic [ANGLE_W-1:0] RIGHT_LO = 15'd2848;
    localparam logic [ANGLE_W-1:0] RIGHT_HI = 15'd2912;
    localparam logic [ANGLE_W-1:0] LEFT_LO  = 15'd20128;
    localparam logic [ANGLE_W-1:0] LEFT_HI  = 15'd20192;
    localparam logic [ANGLE_W-1:0] FRONT_LO = 15'd0;
    localparam logic [ANGLE_W-1:0] FRONT_HI = 15'd64;

    // Division by 40 is a shift by 3 and a multiply by ceil(2^18 / 5)
    localparam int DIV8_SHIFT = 3;
    localparam int RECIP_W    = 16;
    localparam int RECIP_SH   = 18;
    localparam logic [RECIP_W-1:0] RECIP5 = 16'd52429;

    // Operands of the end-of-scan steering update
    typedef struct packed {
        logic [DIST_W-1:0]         cur_right;
        logic [DIST_W-1:0]         cur_left;
        logic signed [DIFF_W-1:0]  prev_difference;
        logic [STEER_W-1:0]        steer_value;
        logic [STEER_W-1:0]        steer_min;
        logic [STEER_W-1:0]        steer_max;
        logic [THR_W-1:0]          deriv_thr;
    } calc_in_t;

    // Outcome of the end-of-scan steering update
    typedef struct packed {
        logic [STEER_W-1:0]        setpoint;
        logic                      dmode;
        logic signed [DIFF_W-1:0]  diff;
    } calc_out_t;

endpackage

// File: rtl/core/lwfs_steer_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering update arithmetic
// Forms the side difference and its change, picks derivative or proportional
// mode, divides the chosen error by 40 toward zero and clamps the setpoint.
// ----------------------------------------------------------------------------
module lwfs_steer_calc
(
    input  lwfs_pkg::calc_in_t  calc_in,
    output lwfs_pkg::calc_out_t calc_out
);

    logic signed [lwfs_pkg::DIFF_W-1:0]   diff;
    logic signed [lwfs_pkg::DIFF_W:0]     var_diff;
    logic [lwfs_pkg::DIFF_W:0]            var_neg;
    logic [lwfs_pkg::DIFF_W-1:0]          diff_neg;
    logic [lwfs_pkg::DIFF_W-1:0]          abs_var;
    logic [lwfs_pkg::DIFF_W-1:0]          abs_diff;
    logic                                 dmode;
    logic [lwfs_pkg::DIFF_W-1:0]          mag;
    logic                                 neg;
    logic [lwfs_pkg::DIFF_W-lwfs_pkg::DIV8_SHIFT-1:0] mag_div8;
    logic [lwfs_pkg::DIFF_W-lwfs_pkg::DIV8_SHIFT+lwfs_pkg::RECIP_W-1:0] prod;
    logic [lwfs_pkg::STEER_W-1:0]         quot;
    logic signed [lwfs_pkg::STEER_W:0]    step;
    logic signed [lwfs_pkg::STEER_W+1:0]  sp;
    logic signed [lwfs_pkg::STEER_W+1:0]  min_ext;
    logic signed [lwfs_pkg::STEER_W+1:0]  max_ext;

    // Right minus left, and its change since the last scan.
    assign diff = $signed({1'b0, calc_in.cur_right}) - $signed({1'b0, calc_in.cur_left});
    assign var_diff = $signed({diff[lwfs_pkg::DIFF_W-1], diff})
                    - $signed({calc_in.prev_difference[lwfs_pkg::DIFF_W-1],
                               calc_in.prev_difference});

    // Magnitudes; both fit in 17 bits for the legal operand ranges.
    assign var_neg  = -var_diff;
    assign diff_neg = -diff;
    assign abs_var  = var_diff[lwfs_pkg::DIFF_W] ? var_neg[lwfs_pkg::DIFF_W-1:0]
                                                 : var_diff[lwfs_pkg::DIFF_W-1:0];
    assign abs_diff = diff[lwfs_pkg::DIFF_W-1] ? diff_neg : diff;

    // Mode select and the error that drives the step.
    assign dmode = (abs_var >= {1'b0, calc_in.deriv_thr});
    assign mag   = dmode ? abs_var : abs_diff;
    assign neg   = dmode ? var_diff[lwfs_pkg::DIFF_W] : diff[lwfs_pkg::DIFF_W-1];

    // floor(mag / 40) = floor(floor(mag / 8) / 5); the reciprocal is exact
    // for every quotient of a 14-bit dividend.
    assign mag_div8 = mag[lwfs_pkg::DIFF_W-1:lwfs_pkg::DIV8_SHIFT];
    assign prod     = mag_div8 * lwfs_pkg::RECIP5;
    assign quot     = prod[lwfs_pkg::RECIP_SH+lwfs_pkg::STEER_W-1:lwfs_pkg::RECIP_SH];
    assign step     = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    // Signed setpoint sum, then clamp with the low limit tested first.
    assign sp      = $signed({2'b00, calc_in.steer_value}) + $signed({step[lwfs_pkg::STEER_W], step});
    assign min_ext = $signed({2'b00, calc_in.steer_min});
    assign max_ext = $signed({2'b00, calc_in.steer_max});

    always_comb
    begin
        if (sp <= min_ext)
        begin
            calc_out.setpoint = calc_in.steer_min;
        end
        else if (sp >= max_ext)
        begin
            calc_out.setpoint = calc_in.steer_max;
        end
        else
        begin
            calc_out.setpoint = sp[lwfs_pkg::STEER_W-1:0];
        end
        calc_out.dmode = dmode;
        calc_out.diff  = diff;
    end

endmodule

// File: rtl/core/lidar_wall_follow_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar wall-follow steering controller
// Filters the right, left and front lidar distances per scan and updates a
// clamped steering setpoint at each end-of-scan transaction.
// ----------------------------------------------------------------------------
// Flow: an accepted end-of-scan transaction is held in the input register, then
// loads the result register, which offers it; a full, stalled result waits.
// Throughput: one transaction per cycle; the input register and the result
// register each hold one item, so only a stalled result slows intake.
// Reset: rst_n clears control state and loads register and distance defaults.
// After a stop result the block drops every transaction until reset.
// ----------------------------------------------------------------------------
module lidar_wall_follow_steering
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration writes
    input  logic                              cfg_we,
    input  logic [lwfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lwfs_pkg::CFG_W-1:0]        cfg_data,

    // Lidar items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // angle_q6[14:0], quality[22:15], range_q2[38:23], zero
    input  logic        s_tuser,   // opcode

    // Steering results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // steer_setpoint[11:0], derivative_mode[12], stop[13],
                                   // front_distance_q2[32:14], side_difference_q2[49:33], zero
);

    // Configuration registers
    logic [lwfs_pkg::STEER_W-1:0] steer_min_reg;
    logic [lwfs_pkg::STEER_W-1:0] steer_max_reg;
    logic [lwfs_pkg::STOPD_W-1:0] stop_dist_reg;
    logic [lwfs_pkg::THR_W-1:0]   deriv_thr_reg;

    // Filter and controller state
    logic [lwfs_pkg::DIST_W-1:0]        prev_right_reg, prev_right_next;
    logic [lwfs_pkg::DIST_W-1:0]        prev_left_reg, prev_left_next;
    logic [lwfs_pkg::FRONT_W-1:0]       prev_front_reg, prev_front_next;
    logic [lwfs_pkg::DIST_W-1:0]        cur_right_reg, cur_right_next;
    logic [lwfs_pkg::DIST_W-1:0]        cur_left_reg, cur_left_next;
    logic [lwfs_pkg::FRONT_W-1:0]       cur_front_reg, cur_front_next;
    logic signed [lwfs_pkg::DIFF_W-1:0] prev_diff_reg, prev_diff_next;
    logic [lwfs_pkg::STEER_W-1:0]       steer_value_reg, steer_value_next;
    logic                               halted_reg, halted_next;

    // Input register
    logic                          in_valid_reg;
    logic                          in_op_reg;
    logic [lwfs_pkg::ANGLE_W-1:0]  in_angle_reg;
    logic [lwfs_pkg::QUAL_W-1:0]   in_quality_reg;
    logic [lwfs_pkg::DIST_W-1:0]   in_dist_reg;

    // Result register
    logic                               out_valid_reg;
    logic [lwfs_pkg::STEER_W-1:0]       out_steer_reg;
    logic                               out_dmode_reg;
    logic                               out_stop_reg;
    logic [lwfs_pkg::FRONT_W-1:0]       out_front_reg;
    logic signed [lwfs_pkg::DIFF_W-1:0] out_diff_reg;

    logic                 in_accept;
    logic                 produce;
    logic                 out_free;
    logic                 work;
    logic                 out_load;
    logic                 node_upd;
    logic                 quality_ok;
    logic                 stop_now;
    logic                 hit_right;
    logic                 hit_left;
    logic                 hit_front;
    logic [lwfs_pkg::DIST_W:0]    sum_right;
    logic [lwfs_pkg::DIST_W:0]    sum_left;
    logic [lwfs_pkg::FRONT_W:0]   sum_front;
    lwfs_pkg::calc_in_t  calc_in;
    lwfs_pkg::calc_out_t calc_out;

    // Handshake: the held item moves on unless it produces a result that
    // cannot enter a full, stalled result register.
    assign produce   = in_valid_reg && (in_op_reg == lwfs_pkg::OP_SCAN_END) && !halted_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign work      = in_valid_reg && (!produce || out_free);
    assign out_load  = work && produce;
    assign node_upd  = work && !halted_reg && (in_op_reg == lwfs_pkg::OP_NODE);
    assign s_tready  = !in_valid_reg || work;
    assign in_accept = s_tvalid && s_tready;

    // Angle windows, tested in right, left, front order.
    assign hit_right = (in_angle_reg > lwfs_pkg::RIGHT_LO) && (in_angle_reg < lwfs_pkg::RIGHT_HI);
    assign hit_left  = (in_angle_reg > lwfs_pkg::LEFT_LO) && (in_angle_reg < lwfs_pkg::LEFT_HI);
    assign hit_front = (in_angle_reg > lwfs_pkg::FRONT_LO) && (in_angle_reg < lwfs_pkg::FRONT_HI);
    assign quality_ok = (in_quality_reg != '0);

    // Floored averages with the previous scan's values.
    assign sum_right = {1'b0, prev_right_reg} + {1'b0, in_dist_reg};
    assign sum_left  = {1'b0, prev_left_reg} + {1'b0, in_dist_reg};
    assign sum_front = {1'b0, prev_front_reg}
                     + {{(lwfs_pkg::FRONT_W - lwfs_pkg::DIST_W + 1){1'b0}}, in_dist_reg};

    // Steering arithmetic for the end of a scan
    assign calc_in.cur_right       = cur_right_reg;
    assign calc_in.cur_left        = cur_left_reg;
    assign calc_in.prev_difference = prev_diff_reg;
    assign calc_in.steer_value     = steer_value_reg;
    assign calc_in.steer_min       = steer_min_reg;
    assign calc_in.steer_max       = steer_max_reg;
    assign calc_in.deriv_thr       = deriv_thr_reg;

    lwfs_steer_calc u_steer_calc
    (
        .calc_in  (calc_in),
        .calc_out (calc_out)
    );

    assign stop_now = (cur_front_reg < {1'b0, stop_dist_reg});

    // Next state of the filter and controller.
    always_comb
    begin
        prev_right_next  = prev_right_reg;
        prev_left_next   = prev_left_reg;
        prev_front_next  = prev_front_reg;
        cur_right_next   = cur_right_reg;
        cur_left_next    = cur_left_reg;
        cur_front_next   = cur_front_reg;
        prev_diff_next   = prev_diff_reg;
        steer_value_next = steer_value_reg;
        halted_next      = halted_reg;

        if (node_upd)
        begin
            if (hit_right)
            begin
                cur_right_next = quality_ok ? sum_right[lwfs_pkg::DIST_W:1] : prev_right_reg;
            end
            else if (hit_left)
            begin
                cur_left_next = quality_ok ? sum_left[lwfs_pkg::DIST_W:1] : prev_left_reg;
            end
            else if (hit_front)
            begin
                cur_front_next = quality_ok ? sum_front[lwfs_pkg::FRONT_W:1] : prev_front_reg;
            end
        end

        if (out_load)
        begin
            steer_value_next = calc_out.setpoint;
            if (stop_now)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                prev_diff_next  = calc_out.diff;
                prev_front_next = cur_front_reg;
                prev_right_next = cur_right_reg;
                prev_left_next  = cur_left_reg;
            end
        end

        // Writing the straight-ahead setpoint also reloads the steering value.
        if (cfg_we && (cfg_index == lwfs_pkg::REG_STEER_START))
        begin
            steer_value_next = cfg_data[lwfs_pkg::STEER_W-1:0];
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_right_reg  <= '0;
            prev_left_reg   <= '0;
            prev_front_reg  <= lwfs_pkg::FRONT_RST;
            cur_right_reg   <= '0;
            cur_left_reg    <= '0;
            cur_front_reg   <= lwfs_pkg::FRONT_RST;
            prev_diff_reg   <= '0;
            steer_value_reg <= lwfs_pkg::STEER_START_RST;
            halted_reg      <= 1'b0;
        end
        else
        begin
            prev_right_reg  <= prev_right_next;
            prev_left_reg   <= prev_left_next;
            prev_front_reg  <= prev_front_next;
            cur_right_reg   <= cur_right_next;
            cur_left_reg    <= cur_left_next;
            cur_front_reg   <= cur_front_next;
            prev_diff_reg   <= prev_diff_next;
            steer_value_reg <= steer_value_next;
            halted_reg      <= halted_next;
        end
    end

    // Configuration registers; unknown indexes are ignored. The straight-ahead
    // setpoint only reloads the steering value in the next-state logic.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_min_reg   <= lwfs_pkg::STEER_MIN_RST;
            steer_max_reg   <= lwfs_pkg::STEER_MAX_RST;
            stop_dist_reg   <= lwfs_pkg::STOP_DIST_RST;
            deriv_thr_reg   <= lwfs_pkg::DERIV_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lwfs_pkg::REG_STEER_MIN:   steer_min_reg   <= cfg_data[lwfs_pkg::STEER_W-1:0];
                lwfs_pkg::REG_STEER_MAX:   steer_max_reg   <= cfg_data[lwfs_pkg::STEER_W-1:0];
                lwfs_pkg::REG_STEER_START: ;
                lwfs_pkg::REG_STOP_DIST:   stop_dist_reg   <= cfg_data[lwfs_pkg::STOPD_W-1:0];
                lwfs_pkg::REG_DERIV_THR:   deriv_thr_reg   <= cfg_data[lwfs_pkg::THR_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg      <= s_tuser;
            in_angle_reg   <= s_tdata[14:0];
            in_quality_reg <= s_tdata[22:15];
            in_dist_reg    <= s_tdata[38:23];
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= out_load;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_steer_reg <= calc_out.setpoint;
            out_dmode_reg <= calc_out.dmode;
            out_stop_reg  <= stop_now;
            out_front_reg <= cur_front_reg;
            out_diff_reg  <= calc_out.diff;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_diff_reg, out_front_reg, out_stop_reg,
                       out_dmode_reg, out_steer_reg};

    // A halted block never stops being halted before reset.
    assert property (@(posedge clk) disable iff (!rst_n) halted_reg |=> halted_reg)
        else $error("halt state was released without reset");

    // No result is produced once the block has halted.
    assert property (@(posedge clk) disable iff (!rst_n) halted_reg |-> !out_load)
        else $error("result produced while halted");

    // A pending stop result implies the block has halted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stop_reg) |-> halted_reg)
        else $error("stop result without halt");

    // A result that stalls stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(m_tdata)))
        else $error("result register changed while stalled");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar wall-follow steering testbench
// Sends lidar measurement nodes and end-of-scan transactions to the steering
// controller. A behavioral copy of the filter and steering law predicts each
// result, and every result is compared field by field. The run starts with a
// table of hand-picked items and then sends random scans under several
// register settings. It ends with a stop, after which the block must stay
// silent.
// ----------------------------------------------------------------------------
module testbench;

    import lwfs_pkg::*;

    localparam int          ITEMS          = 1500;
    localparam int          PHASES         = 8;
    localparam int          ITEMS_PER_PH   = ITEMS / PHASES;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          POST_STOP_ITEMS = 24;
    localparam int unsigned CYCLE_LIMIT    = 600000;
    localparam int          DIR_N          = 23;
    localparam logic [CFG_IDX_W-1:0] REG_LAST = REG_DERIV_THR;
    localparam logic [STOPD_W-1:0]   STOPD_MAX = {STOPD_W{1'b1}};

    // Angle classes of a measurement node
    typedef enum logic [1:0] {DIR_NONE, DIR_RIGHT, DIR_LEFT, DIR_FRONT} window_t;

    // One steering result as it leaves the block
    typedef struct packed {
        logic [STEER_W-1:0]       setpoint;
        logic                     dmode;
        logic                     stop;
        logic [FRONT_W-1:0]       front;
        logic signed [DIFF_W-1:0] diff;
    } steer_result_t;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic                op;
        logic [ANGLE_W-1:0]  angle;
        logic [QUAL_W-1:0]   qual;
        logic [DIST_W-1:0]   sample;
        logic                typed;
        steer_result_t       want;
    } stim_row_t;

    // Window edges, quality zero, duplicate hits, scans with no hits, clamps
    localparam stim_row_t DIRECTED [DIR_N] = '{
        '{OP_SCAN_END, 15'd0,     8'd0,   16'd0,     1'b1,
          '{12'd1540, 1'b0, 1'b0, 19'd400000, 17'sd0}},
        '{OP_NODE,     15'd2848,  8'd255, 16'd65535, 1'b0, '0},
        '{OP_NODE,     15'd2849,  8'd255, 16'd65535, 1'b0, '0},
        '{OP_NODE,     15'd20191, 8'd1,   16'd1000,  1'b0, '0},
        '{OP_NODE,     15'd63,    8'd7,   16'd65535, 1'b0, '0},
        '{OP_NODE,     15'd0,     8'd255, 16'd0,     1'b0, '0},
        '{OP_NODE,     15'd64,    8'd255, 16'd0,     1'b0, '0},
        '{OP_NODE,     15'd2912,  8'd255, 16'd0,     1'b0, '0},
        '{OP_NODE,     15'd20128, 8'd255, 16'd0,     1'b0, '0},
        '{OP_NODE,     15'd20192, 8'd255, 16'd0,     1'b0, '0},
        '{OP_NODE,     15'd32767, 8'd255, 16'd65535, 1'b0, '0},
        '{OP_SCAN_END, 15'd32767, 8'd255, 16'd65535, 1'b1,
          '{12'd1810, 1'b1, 1'b0, 19'd232767, 17'sd32267}},
        '{OP_NODE,     15'd2880,  8'd0,   16'd12345, 1'b0, '0},
        '{OP_NODE,     15'd20160, 8'd255, 16'd65535, 1'b0, '0},
        '{OP_NODE,     15'd20130, 8'd255, 16'd0,     1'b0, '0},
        '{OP_NODE,     15'd1,     8'd0,   16'd0,     1'b0, '0},
        '{OP_SCAN_END, 15'd0,     8'd0,   16'd0,     1'b0, '0},
        '{OP_NODE,     15'd2849,  8'd255, 16'd0,     1'b0, '0},
        '{OP_NODE,     15'd20191, 8'd255, 16'd65535, 1'b0, '0},
        '{OP_SCAN_END, 15'd0,     8'd0,   16'd0,     1'b0, '0},
        '{OP_SCAN_END, 15'd0,     8'd0,   16'd0,     1'b0, '0},
        '{OP_NODE,     15'd32,    8'd128, 16'd8800,  1'b0, '0},
        '{OP_SCAN_END, 15'd0,     8'd0,   16'd0,     1'b0, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;   // angle_q6[14:0], quality[22:15], range_q2[38:23], zero
    logic               s_tuser;   // opcode
    logic               m_tvalid;
    logic               m_tready;
    logic [55:0]        m_tdata;   // steer_setpoint[11:0], derivative_mode[12], stop[13],
                                   // front_distance_q2[32:14], side_difference_q2[49:33], zero

    // Predicted register contents
    logic [STEER_W-1:0] lim_min   = STEER_MIN_RST;
    logic [STEER_W-1:0] lim_max   = STEER_MAX_RST;
    logic [STOPD_W-1:0] stop_dist = STOP_DIST_RST;
    logic [THR_W-1:0]   dthr      = DERIV_THR_RST;

    // Predicted filter and steering state
    logic [DIST_W-1:0]  last_right = '0;
    logic [DIST_W-1:0]  last_left  = '0;
    logic [FRONT_W-1:0] last_front = FRONT_RST;
    logic [DIST_W-1:0]  live_right = '0;
    logic [DIST_W-1:0]  live_left  = '0;
    logic [FRONT_W-1:0] live_front = FRONT_RST;
    int                 last_diff  = 0;
    logic [STEER_W-1:0] steer_pos  = STEER_START_RST;
    bit                 stopped    = 1'b0;

    steer_result_t expected_steer [$];

    int          items_sent       = 0;
    int          useful_items     = 0;
    int          results_checked  = 0;
    int          dmode_results    = 0;
    int          stop_results     = 0;
    int          settings_applied = 0;
    int          mismatches       = 0;
    int unsigned cycle_count      = 0;
    bit          steady_flow      = 1'b0;
    bit          rx_hold_req      = 1'b0;

    lidar_wall_follow_steering dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock generation
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_steer.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sort an angle into the right, left or front window, if any
    function automatic window_t window_of(input logic [ANGLE_W-1:0] a);
        if (a > RIGHT_LO && a < RIGHT_HI)
            return DIR_RIGHT;
        else if (a > LEFT_LO && a < LEFT_HI)
            return DIR_LEFT;
        else if (a > FRONT_LO && a < FRONT_HI)
            return DIR_FRONT;
        return DIR_NONE;
    endfunction

    // Advance the predicted state by one accepted item; returns 1 with a result
    function automatic bit predict_steering(input logic op, input logic [ANGLE_W-1:0] angle,
                                            input logic [QUAL_W-1:0] qual,
                                            input logic [DIST_W-1:0] sample,
                                            output steer_result_t res);
        int diff;
        int delta;
        int mag;
        int sp;
        bit dm;
        res = '0;
        if (stopped)
            return 1'b0;

        // A node averages the sample with the value latched at the last scan end
        if (op == OP_NODE)
        begin
            case (window_of(angle))
                DIR_RIGHT: live_right = (qual != '0) ?
                    DIST_W'((int'(last_right) + int'(sample)) >> 1) : last_right;
                DIR_LEFT:  live_left = (qual != '0) ?
                    DIST_W'((int'(last_left) + int'(sample)) >> 1) : last_left;
                DIR_FRONT: live_front = (qual != '0) ?
                    FRONT_W'((int'(last_front) + int'(sample)) >> 1) : last_front;
                default: ;
            endcase
            return 1'b0;
        end

        // Scan end: pick derivative or proportional step, then clamp
        diff  = int'(live_right) - int'(live_left);
        delta = diff - last_diff;
        mag   = (delta < 0) ? -delta : delta;
        dm    = (mag >= int'(dthr));
        sp    = int'(steer_pos) + (dm ? delta / 40 : diff / 40);
        if (sp <= int'(lim_min))
            sp = int'(lim_min);
        else if (sp >= int'(lim_max))
            sp = int'(lim_max);
        steer_pos = STEER_W'(sp);

        res.setpoint = steer_pos;
        res.dmode    = dm;
        res.stop     = (live_front < stop_dist);
        res.front    = live_front;
        res.diff     = DIFF_W'(diff);

        // A stop halts the block for good and latches nothing
        if (res.stop)
            stopped = 1'b1;
        else
        begin
            last_diff  = diff;
            last_front = live_front;
            last_right = live_right;
            last_left  = live_left;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 3);
    endfunction

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        steer_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_steer.size() == 0)
            begin
                $error("Steering result with none expected: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_steer.pop_front();
                check_field("steer_setpoint", want.setpoint, m_tdata[11:0]);
                check_field("derivative_mode", want.dmode, m_tdata[12]);
                check_field("stop", want.stop, m_tdata[13]);
                check_field("front_distance_q2", want.front, m_tdata[32:14]);
                check_field("side_difference_q2", $signed(want.diff),
                            $signed(m_tdata[49:33]));
                results_checked++;
                if (m_tdata[12])
                    dmode_results++;
                if (m_tdata[13])
                    stop_results++;
            end
        end
    end

    // Result side: random stalls, steady stretches and one long hold-off
    initial
    begin : receiver
        int hold;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                for (hold = 0; hold < RX_HOLD_CYCLES; hold++)
                    @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!steady_flow && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one item and wait for the transaction; record what it should cause
    task automatic send_item(input logic op, input logic [ANGLE_W-1:0] angle,
                             input logic [QUAL_W-1:0] qual, input logic [DIST_W-1:0] sample,
                             input logic typed, input steer_result_t typed_res);
        steer_result_t res;
        bit produced;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, sample, qual, angle};
        do
            @(posedge clk);
        while (!s_tready);
        produced = predict_steering(op, angle, qual, sample, res);
        if (typed)
            expected_steer.push_back(typed_res);
        else if (produced)
            expected_steer.push_back(res);
        items_sent++;
        if (op == OP_SCAN_END || window_of(angle) != DIR_NONE)
            useful_items++;
    endtask

    task automatic sender_gap();
        if (!steady_flow && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
    endtask

    // Stop sending, let every result drain, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_steer.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_STEER_MIN:   lim_min = data[STEER_W-1:0];
            REG_STEER_MAX:   lim_max = data[STEER_W-1:0];
            REG_STEER_START: steer_pos = data[STEER_W-1:0];
            REG_STOP_DIST:   stop_dist = data[STOPD_W-1:0];
            REG_DERIV_THR:   dthr = data[THR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Write every register; unused upper data bits carry noise
    task automatic apply_settings(input logic [STEER_W-1:0] smin, input logic [STEER_W-1:0] smax,
                                  input logic [STEER_W-1:0] sstart,
                                  input logic [STOPD_W-1:0] sdist, input logic [THR_W-1:0] thr,
                                  input logic [CFG_IDX_W-1:0] spare_idx);
        cfg_write(REG_STEER_MIN, {6'($urandom), smin});
        cfg_write(REG_STEER_MAX, {6'($urandom), smax});
        cfg_write(REG_STEER_START, {6'($urandom), sstart});
        cfg_write(REG_STOP_DIST, sdist);
        cfg_write(REG_DERIV_THR, {2'($urandom), thr});
        cfg_write(spare_idx, CFG_W'($urandom));
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // One measurement node aimed at a window, or anywhere for noise
    task automatic send_node(input window_t dir);
        logic [ANGLE_W-1:0] angle;
        logic [QUAL_W-1:0]  qual;
        logic [DIST_W-1:0]  sample;
        case (dir)
            DIR_RIGHT: angle = ANGLE_W'($urandom_range(RIGHT_LO + 1, RIGHT_HI - 1));
            DIR_LEFT:  angle = ANGLE_W'($urandom_range(LEFT_LO + 1, LEFT_HI - 1));
            DIR_FRONT: angle = ANGLE_W'($urandom_range(FRONT_LO + 1, FRONT_HI - 1));
            default:   angle = ANGLE_W'($urandom);
        endcase
        qual = ($urandom_range(0, 4) == 0) ? '0 : QUAL_W'($urandom_range(1, 255));
        case ($urandom_range(0, 9))
            0:       sample = '0;
            1:       sample = '1;
            default: sample = DIST_W'($urandom);
        endcase
        // Keep the filtered front distance at or above the stop distance
        if (window_of(angle) == DIR_FRONT && sample < stop_dist)
            sample = ($urandom_range(0, 7) == 0) ? DIST_W'(stop_dist) :
                     DIST_W'($urandom_range(int'(stop_dist), 65535));
        sender_gap();
        send_item(OP_NODE, angle, qual, sample, 1'b0, '0);
    endtask

    // A scan: a few nodes, mostly in the windows, then the scan end
    task automatic run_scan();
        int nodes;
        int k;
        int pick;
        nodes = $urandom_range(0, 6);
        for (k = 0; k < nodes; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                send_node(DIR_RIGHT);
            else if (pick < 6)
                send_node(DIR_LEFT);
            else if (pick < 8)
                send_node(DIR_FRONT);
            else
                send_node(DIR_NONE);
        end
        sender_gap();
        send_item(OP_SCAN_END, ANGLE_W'($urandom), QUAL_W'($urandom), DIST_W'($urandom),
                  1'b0, '0);
    endtask

    // Main sequence
    initial
    begin : stimulus
        int ph;
        int k;
        int bound;
        int phase_start;
        logic [CFG_IDX_W-1:0] spare_idx;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_NODE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset settings
        for (k = 0; k < DIR_N; k++)
        begin
            sender_gap();
            send_item(DIRECTED[k].op, DIRECTED[k].angle, DIRECTED[k].qual, DIRECTED[k].sample,
                      DIRECTED[k].typed, DIRECTED[k].want);
        end
        wait_idle();

        // Random scans under a series of settings
        for (ph = 0; ph < PHASES; ph++)
        begin
            // The stop distance never exceeds the front distances already filtered
            bound = (live_front < last_front) ? int'(live_front) : int'(last_front);
            if (bound > 65535)
                bound = 65535;
            spare_idx = CFG_IDX_W'(int'(REG_LAST) + 1 + (ph % 3));
            case (ph)
                0: apply_settings(STEER_MIN_RST, STEER_MAX_RST, STEER_START_RST,
                                  (bound < int'(STOP_DIST_RST)) ? STOPD_W'(bound) : STOP_DIST_RST,
                                  DERIV_THR_RST, spare_idx);
                1: apply_settings('1, '0, 12'd100, STOPD_W'($urandom_range(0, bound)), '1,
                                  spare_idx);
                2: apply_settings('0, '1, 12'd2048, '0, '0, spare_idx);
                default: apply_settings(STEER_W'($urandom_range(0, 2000)),
                                        STEER_W'($urandom_range(2100, 4095)),
                                        STEER_W'($urandom_range(0, 4095)),
                                        STOPD_W'($urandom_range(0, bound)),
                                        ($urandom_range(0, 3) == 0) ?
                                            THR_W'($urandom) : THR_W'($urandom_range(0, 64)),
                                        spare_idx);
            endcase
            steady_flow = (ph % 3 == 2);
            // The sender keeps offering items while the result side holds off
            if (ph == 3)
                rx_hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PH)
                run_scan();
            wait_idle();
        end
        steady_flow = 1'b0;

        // Stop at the largest stop distance; everything after it is dropped
        cfg_write(REG_STOP_DIST, STOPD_MAX);
        cfg_we <= 1'b0;
        send_item(OP_NODE, ANGLE_W'(int'(FRONT_LO) + 1), 8'd9, 16'd0, 1'b0, '0);
        sender_gap();
        send_item(OP_SCAN_END, '0, '0, '0, 1'b0, '0);
        for (k = 0; k < POST_STOP_ITEMS; k++)
        begin
            sender_gap();
            send_item(1'($urandom), ANGLE_W'($urandom), QUAL_W'($urandom), DIST_W'($urandom),
                      1'b0, '0);
        end
        wait_idle();

        $display("Run covered %0d lidar items (%0d in a window or ending a scan) and %0d results",
                 items_sent, useful_items, results_checked);
        $display("(%0d derivative, %0d stop) over %0d register settings, reversed clamps included.",
                 dmode_results, stop_results, settings_applied);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
